// ===== hw/rtl/pidc_pkg.sv =====
// Package of shared types and constants for the clamped positional PID block.
package pidc_pkg;

    localparam int FIELD_W   = 32;
    localparam int GAIN_W    = 32;
    localparam int LIM_W     = 31;
    localparam int GAIN_FRAC = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_ERR_PAIR   = 2'd0,
        OP_ERR_DIRECT = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_IGNORE     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_PROP_LIMIT   = 3'd3,
        CFG_INTEG_LIMIT  = 3'd4,
        CFG_DERIV_LIMIT  = 3'd5,
        CFG_OUTPUT_LIMIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [FIELD_W-1:0] setpoint;
        logic signed [FIELD_W-1:0] measured;
        logic signed [FIELD_W-1:0] direct_error;
    } t_pid_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] control_out;
        logic signed [FIELD_W-1:0] p_term;
        logic signed [FIELD_W-1:0] i_term;
        logic signed [FIELD_W-1:0] d_term;
    } t_pid_out;

endpackage

// ===== hw/rtl/positional_pid_term_clamped.sv =====
// Top level of the clamped positional PID step: error, history, three terms and output clamp.
//
//   Channel   Direction  Handshake             Beat
//   input     in         i_valid / o_stall     i_in  (pidc_pkg::t_pid_in)
//   result    out        o_valid / i_stall     o_out (pidc_pkg::t_pid_out)
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One beat is accepted per cycle while o_stall is low; its result reaches o_out through
// five register stages: error, history update, partial products,
// clamped terms and clamped sum. A beat with the ignore opcode leaves no result.
// While the result register is full and stalled, the whole pipeline holds and o_stall is high.
// Reset clears the history, the gains, the limits and every valid flag.
module positional_pid_term_clamped #(
    parameter int DATA_WIDTH = 32,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  pidc_pkg::t_pid_in                     i_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output pidc_pkg::t_pid_out                    o_out,
    input  logic                                  i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pidc_pkg::GAIN_W-1:0]           i_cfg_data
);

    localparam int FW = pidc_pkg::FIELD_W;
    localparam int EW = (DATA_WIDTH > FW + 1) ? DATA_WIDTH : FW + 1;
    localparam int SW = ((ACC_WIDTH > DATA_WIDTH) ? ACC_WIDTH : DATA_WIDTH) + 1;
    localparam int TW = FW + 2;

    localparam logic signed [EW-1:0] ERR_MAX =
        {{(EW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [EW-1:0] ERR_MIN = ~ERR_MAX;
    localparam logic signed [SW-1:0] SUM_MAX =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;

    // Configuration registers.
    logic signed [pidc_pkg::GAIN_W-1:0] r_prop_gain;
    logic signed [pidc_pkg::GAIN_W-1:0] r_integ_gain;
    logic signed [pidc_pkg::GAIN_W-1:0] r_deriv_gain;
    logic        [pidc_pkg::LIM_W-1:0]  r_prop_limit;
    logic        [pidc_pkg::LIM_W-1:0]  r_integ_limit;
    logic        [pidc_pkg::LIM_W-1:0]  r_deriv_limit;
    logic        [pidc_pkg::LIM_W-1:0]  r_output_limit;

    // History.
    logic signed [DATA_WIDTH-1:0] r_last_err;
    logic signed [ACC_WIDTH-1:0]  r_err_sum;

    // Pipeline control.
    logic adv;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_o_valid;
    logic r_s1_clr, r_s2_clr, r_s3_clr, r_s4_clr;

    // Pipeline payload.
    logic signed [DATA_WIDTH-1:0] r_s1_err;
    logic signed [DATA_WIDTH-1:0] r_s2_err;
    logic signed [ACC_WIDTH-1:0]  r_s2_sum;
    logic signed [DATA_WIDTH:0]   r_s2_diff;
    pidc_pkg::t_pid_out           r_out;

    logic signed [FW:0]           pair_diff;
    logic signed [EW-1:0]         wide_err;
    logic signed [DATA_WIDTH-1:0] n_err;
    logic signed [SW-1:0]         wide_sum;
    logic signed [ACC_WIDTH-1:0]  n_sum;
    logic signed [DATA_WIDTH:0]   n_diff;
    logic signed [FW-1:0]         p_val, i_val, d_val;
    logic signed [TW-1:0]         tot;
    logic signed [TW-1:0]         out_lim;
    pidc_pkg::t_pid_out           n_out;

    // The whole pipeline moves whenever the result register can take a beat.
    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_o_valid;
    assign o_out   = r_out;

    // Error of the incoming beat, saturated to the history width.
    always_comb begin
        pair_diff = (FW + 1)'(i_in.setpoint) - (FW + 1)'(i_in.measured);
        if (i_in.opcode == pidc_pkg::OP_ERR_DIRECT) begin
            wide_err = EW'(i_in.direct_error);
        end else begin
            wide_err = EW'(pair_diff);
        end
        if (wide_err > ERR_MAX) begin
            n_err = DATA_WIDTH'(ERR_MAX);
        end else if (wide_err < ERR_MIN) begin
            n_err = DATA_WIDTH'(ERR_MIN);
        end else begin
            n_err = DATA_WIDTH'(wide_err);
        end
    end

    // Saturating running sum and change from the previous error.
    always_comb begin
        wide_sum = SW'(r_err_sum) + SW'(r_s1_err);
        if (wide_sum > SUM_MAX) begin
            n_sum = ACC_WIDTH'(SUM_MAX);
        end else if (wide_sum < SUM_MIN) begin
            n_sum = ACC_WIDTH'(SUM_MIN);
        end else begin
            n_sum = ACC_WIDTH'(wide_sum);
        end
        n_diff = (DATA_WIDTH + 1)'(r_s1_err) - (DATA_WIDTH + 1)'(r_last_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_deriv_gain   <= '0;
            r_prop_limit   <= '0;
            r_integ_limit  <= '0;
            r_deriv_limit  <= '0;
            r_output_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (pidc_pkg::t_cfg_idx'(i_cfg_idx))
                pidc_pkg::CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                pidc_pkg::CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data;
                pidc_pkg::CFG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data;
                pidc_pkg::CFG_PROP_LIMIT:   r_prop_limit   <= i_cfg_data[pidc_pkg::LIM_W-1:0];
                pidc_pkg::CFG_INTEG_LIMIT:  r_integ_limit  <= i_cfg_data[pidc_pkg::LIM_W-1:0];
                pidc_pkg::CFG_DERIV_LIMIT:  r_deriv_limit  <= i_cfg_data[pidc_pkg::LIM_W-1:0];
                pidc_pkg::CFG_OUTPUT_LIMIT: r_output_limit <= i_cfg_data[pidc_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_s1_clr   <= 1'b0;
            r_s2_clr   <= 1'b0;
            r_s3_clr   <= 1'b0;
            r_s4_clr   <= 1'b0;
            r_last_err <= '0;
            r_err_sum  <= '0;
        end else if (adv) begin
            r_s1_valid <= i_valid && (i_in.opcode != pidc_pkg::OP_IGNORE);
            r_s1_clr   <= i_in.opcode == pidc_pkg::OP_CLEAR;
            r_s2_valid <= r_s1_valid;
            r_s2_clr   <= r_s1_clr;
            r_s3_valid <= r_s2_valid;
            r_s3_clr   <= r_s2_clr;
            r_s4_valid <= r_s3_valid;
            r_s4_clr   <= r_s3_clr;
            r_o_valid  <= r_s4_valid;
            if (r_s1_valid) begin
                if (r_s1_clr) begin
                    r_last_err <= '0;
                    r_err_sum  <= '0;
                end else begin
                    r_last_err <= r_s1_err;
                    r_err_sum  <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_err  <= n_err;
            r_s2_err  <= r_s1_err;
            r_s2_sum  <= n_sum;
            r_s2_diff <= n_diff;
            r_out     <= n_out;
        end
    end

    pidc_term #(.OPW(DATA_WIDTH)) u_p_term (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_gain (r_prop_gain),
        .i_opnd (r_s2_err),
        .i_lim  (r_prop_limit),
        .o_term (p_val)
    );

    pidc_term #(.OPW(ACC_WIDTH)) u_i_term (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_gain (r_integ_gain),
        .i_opnd (r_s2_sum),
        .i_lim  (r_integ_limit),
        .o_term (i_val)
    );

    pidc_term #(.OPW(DATA_WIDTH + 1)) u_d_term (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_gain (r_deriv_gain),
        .i_opnd (r_s2_diff),
        .i_lim  (r_deriv_limit),
        .o_term (d_val)
    );

    // Sum of the clamped terms, clamped to the output limit; a clear beat reports all zeros.
    always_comb begin
        tot     = TW'(p_val) + TW'(i_val) + TW'(d_val);
        out_lim = TW'(signed'({1'b0, r_output_limit}));
        n_out.p_term = p_val;
        n_out.i_term = i_val;
        n_out.d_term = d_val;
        if (tot > out_lim) begin
            n_out.control_out = FW'(out_lim);
        end else if (tot < -out_lim) begin
            n_out.control_out = FW'(-out_lim);
        end else begin
            n_out.control_out = FW'(tot);
        end
        if (r_s4_clr) begin
            n_out = '0;
        end
    end

endmodule

// ===== hw/rtl/pidc_term.sv =====
// One PID term: split gain multiply, floor shift by the gain fraction and symmetric clamp.
module pidc_term #(
    parameter int OPW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  i_gain,
    input  logic signed [OPW-1:0]               i_opnd,
    input  logic        [pidc_pkg::LIM_W-1:0]   i_lim,
    output logic signed [pidc_pkg::FIELD_W-1:0] o_term
);

    localparam int LO_W = OPW / 2;
    localparam int HI_W = OPW - LO_W;
    localparam int LO_P = pidc_pkg::GAIN_W + LO_W + 1;
    localparam int HI_P = pidc_pkg::GAIN_W + HI_W;
    localparam int PW   = pidc_pkg::GAIN_W + OPW;

    logic signed [LO_P-1:0] r_lo_pp;
    logic signed [HI_P-1:0] r_hi_pp;
    logic signed [LO_P-1:0] n_lo_pp;
    logic signed [HI_P-1:0] n_hi_pp;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   quo;
    logic signed [PW-1:0]   lim_w;
    logic signed [pidc_pkg::FIELD_W-1:0] r_term;
    logic signed [pidc_pkg::FIELD_W-1:0] n_term;

    // The low half of the operand is taken as an unsigned digit, the high half carries the sign.
    always_comb begin
        n_lo_pp = LO_P'(i_gain) * LO_P'(signed'({1'b0, i_opnd[LO_W-1:0]}));
        n_hi_pp = HI_P'(i_gain) * HI_P'(signed'(i_opnd[OPW-1:LO_W]));
    end

    // An arithmetic right shift of the exact product rounds towards minus infinity.
    always_comb begin
        prod  = (PW'(r_hi_pp) <<< LO_W) + PW'(r_lo_pp);
        quo   = prod >>> pidc_pkg::GAIN_FRAC;
        lim_w = PW'(signed'({1'b0, i_lim}));
        if (quo > lim_w) begin
            n_term = pidc_pkg::FIELD_W'(lim_w);
        end else if (quo < -lim_w) begin
            n_term = pidc_pkg::FIELD_W'(-lim_w);
        end else begin
            n_term = pidc_pkg::FIELD_W'(quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_pp <= n_lo_pp;
            r_hi_pp <= n_hi_pp;
            r_term  <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

// ===== test/tb_positional_pid_term_clamped.sv =====
// Self-checking testbench for the clamped positional PID block, with its own predictor.
module tb_positional_pid_term_clamped;

    localparam int CYCLE_LIMIT = 1_000_000;
    // The pipeline is five stages deep; FLUSH_CYCLES covers any beat still in flight.
    localparam int FLUSH_CYCLES = 8;

    localparam logic signed [32:0] ERR_MAX = 33'sd2147483647;
    localparam logic signed [32:0] ERR_MIN = -33'sd2147483648;
    localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pidc_pkg::t_pid_in in_beat = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pidc_pkg::t_pid_out out_beat;
    logic cfg_we = 1'b0;
    logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [pidc_pkg::GAIN_W-1:0] cfg_data = '0;

    // Predictor state and its copy of the registers.
    logic signed [31:0] kp = '0, ki = '0, kd = '0;
    logic [30:0] lim_p = '0, lim_i = '0, lim_d = '0, lim_out = '0;
    logic signed [31:0] prev_err = '0;
    logic signed [47:0] err_acc = '0;

    pidc_pkg::t_pid_in beats_to_send[$];
    pidc_pkg::t_pid_out pid_results_due[$];

    logic in_fire = 1'b0;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int cycle_count = 0;

    positional_pid_term_clamped dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_in       (in_beat),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_out      (out_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // floor(gain * operand / 2^GAIN_FRAC), then clamped to [-lim, lim].
    function automatic logic signed [31:0] scaled_term(input logic signed [31:0] gain,
                                                       input logic signed [48:0] operand,
                                                       input logic [30:0] lim);
        logic signed [95:0] g;
        logic signed [95:0] o;
        logic signed [95:0] prod;
        logic signed [95:0] cap;
        g = 96'(gain);
        o = 96'(operand);
        cap = {65'd0, lim};
        prod = (g * o) >>> pidc_pkg::GAIN_FRAC;
        if (prod > cap) begin
            prod = cap;
        end else if (prod < -cap) begin
            prod = -cap;
        end
        return prod[31:0];
    endfunction

    task automatic advance_pid(input pidc_pkg::t_pid_in b);
        logic signed [32:0] diff;
        logic signed [31:0] err;
        logic signed [48:0] acc_next;
        logic signed [48:0] delta;
        logic signed [33:0] total;
        logic signed [33:0] cap;
        pidc_pkg::t_pid_out r;
        r = '0;
        case (b.opcode)
            pidc_pkg::OP_IGNORE: return;
            pidc_pkg::OP_CLEAR: begin
                prev_err = '0;
                err_acc = '0;
            end
            default: begin
                if (b.opcode == pidc_pkg::OP_ERR_PAIR) begin
                    diff = 33'(b.setpoint) - 33'(b.measured);
                    if (diff > ERR_MAX) diff = ERR_MAX;
                    else if (diff < ERR_MIN) diff = ERR_MIN;
                    err = diff[31:0];
                end else begin
                    err = b.direct_error;
                end
                acc_next = 49'(err_acc) + 49'(err);
                if (acc_next > ACC_MAX) acc_next = ACC_MAX;
                else if (acc_next < ACC_MIN) acc_next = ACC_MIN;
                err_acc = acc_next[47:0];
                delta = 49'(err) - 49'(prev_err);
                prev_err = err;
                r.p_term = scaled_term(kp, 49'(err), lim_p);
                r.i_term = scaled_term(ki, 49'(err_acc), lim_i);
                r.d_term = scaled_term(kd, delta, lim_d);
                total = 34'(r.p_term) + 34'(r.i_term) + 34'(r.d_term);
                cap = {3'd0, lim_out};
                if (total > cap) total = cap;
                else if (total < -cap) total = -cap;
                r.control_out = total[31:0];
            end
        endcase
        pid_results_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_result(input pidc_pkg::t_pid_out got);
        pidc_pkg::t_pid_out want;
        if (pid_results_due.size() == 0) begin
            report_mismatch("result with none due, control_out", got.control_out, '0);
        end else begin
            want = pid_results_due.pop_front();
            if (got.control_out !== want.control_out)
                report_mismatch("control_out", got.control_out, want.control_out);
            if (got.p_term !== want.p_term) report_mismatch("p_term", got.p_term, want.p_term);
            if (got.i_term !== want.i_term) report_mismatch("i_term", got.i_term, want.i_term);
            if (got.d_term !== want.d_term) report_mismatch("d_term", got.d_term, want.d_term);
        end
        results_seen++;
    endtask

    // Monitor: results are checked and accepted beats predicted at the rising edge.
    always @(posedge clk) begin
        in_fire <= in_valid && !in_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) check_result(out_beat);
            if (in_valid && !in_stall) advance_pid(in_beat);
        end
    end

    // Driver: a new beat is offered only once the previous one has gone.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_fire) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_beat <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= $urandom_range(99) < stall_pct;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("positional_pid_term_clamped verification failed");
            $finish;
        end
    end

    task automatic write_reg(input pidc_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            pidc_pkg::CFG_PROP_GAIN:    kp = val;
            pidc_pkg::CFG_INTEG_GAIN:   ki = val;
            pidc_pkg::CFG_DERIV_GAIN:   kd = val;
            pidc_pkg::CFG_PROP_LIMIT:   lim_p = val[30:0];
            pidc_pkg::CFG_INTEG_LIMIT:  lim_i = val[30:0];
            pidc_pkg::CFG_DERIV_LIMIT:  lim_d = val[30:0];
            pidc_pkg::CFG_OUTPUT_LIMIT: lim_out = val[30:0];
            default: ;
        endcase
    endtask

    task automatic load_gains_and_limits(input logic [31:0] g_p, g_i, g_d,
                                         input logic [31:0] l_p, l_i, l_d, l_out);
        write_reg(pidc_pkg::CFG_PROP_GAIN, g_p);
        write_reg(pidc_pkg::CFG_INTEG_GAIN, g_i);
        write_reg(pidc_pkg::CFG_DERIV_GAIN, g_d);
        write_reg(pidc_pkg::CFG_PROP_LIMIT, l_p);
        write_reg(pidc_pkg::CFG_INTEG_LIMIT, l_i);
        write_reg(pidc_pkg::CFG_DERIV_LIMIT, l_d);
        write_reg(pidc_pkg::CFG_OUTPUT_LIMIT, l_out);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        while (beats_to_send.size() != 0 || in_valid) @(posedge clk);
        while (pid_results_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0, 1: return r;
            2: return {{12{r[31]}}, r[19:0]};
            3: return {{6{r[31]}}, r[25:0]};
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(4))
            0: return r;
            1, 2: return {{9{r[31]}}, r[22:0]};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(1) ? 32'h0010_0000 : 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(4))
            0: return r;
            1, 2: return {8'd0, r[23:0]};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic pidc_pkg::t_pid_in make_beat(input pidc_pkg::t_opcode op,
                                                    input logic [31:0] sp, m, e);
        pidc_pkg::t_pid_in b;
        b.opcode = op;
        b.setpoint = sp;
        b.measured = m;
        b.direct_error = e;
        return b;
    endfunction

    function automatic pidc_pkg::t_pid_in random_beat();
        pidc_pkg::t_pid_in b;
        int unsigned r;
        r = $urandom_range(99);
        b = make_beat(pidc_pkg::OP_ERR_PAIR, pick_q16(), pick_q16(), pick_q16());
        if (r >= 95) b.opcode = pidc_pkg::OP_IGNORE;
        else if (r >= 90) b.opcode = pidc_pkg::OP_CLEAR;
        else if (r >= 45) b.opcode = pidc_pkg::OP_ERR_DIRECT;
        return b;
    endfunction

    initial begin
        int unsigned gap_table[5] = '{0, 45, 0, 19, 0};
        int unsigned stall_table[5] = '{0, 0, 45, 19, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats: gains 1.5, -0.75 and 0.25; the deriv limit write has bit 31 set.
        load_gains_and_limits(32'h0018_0000, 32'hFFF4_0000, 32'h0004_0000,
                              32'h7FFF_FFFF, 32'h03E8_0000, 32'hFFFF_FFFF, 32'h4000_0000);
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'h0));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'h1));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'hFFFF_FFFF));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'hFFFF_FFFD));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'h7FFF_FFFF));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'h8000_0000));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h7FFF_FFFF,
                                          32'h8000_0000, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h8000_0000,
                                          32'h7FFF_FFFF, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h8000_0000,
                                          32'h8000_0000, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h7FFF_FFFF,
                                          32'hFFFF_FFFF, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h0005_8000,
                                          32'h0002_4000, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_IGNORE, $urandom, $urandom,
                                          $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_PAIR, 32'h0001_0000,
                                          32'h0003_0000, $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_CLEAR, $urandom, $urandom,
                                          $urandom));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'h0000_8001));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_ERR_DIRECT, $urandom, $urandom,
                                          32'hFFFF_7FFF));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_IGNORE, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        beats_to_send.push_back(make_beat(pidc_pkg::OP_CLEAR, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        beats_to_send.push_back(random_beat());
        beats_to_send.push_back(random_beat());
        drain_results();
        repeat (FLUSH_CYCLES) @(posedge clk);

        for (int ph = 0; ph < 5; ph++) begin
            send_gap_pct = gap_table[ph];
            stall_pct = stall_table[ph];
            case (ph)
                2: load_gains_and_limits(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF);
                3: load_gains_and_limits(pick_gain(), pick_gain(), pick_gain(),
                                         32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
                4: load_gains_and_limits(32'h8000_0000, pick_gain(), 32'h8000_0000,
                                         pick_limit(), 32'h0, pick_limit(), pick_limit());
                default: load_gains_and_limits(pick_gain(), pick_gain(), pick_gain(),
                                               pick_limit(), pick_limit(), pick_limit(),
                                               pick_limit());
            endcase
            for (int n = 0; n < 290; n++) begin
                beats_to_send.push_back(random_beat());
                // Halfway through the first idling phase the input holds until the output is empty.
                if (ph == 1 && n == 145) drain_results();
            end
            drain_results();
            repeat (FLUSH_CYCLES) @(posedge clk);
        end

        if (mismatch_count == 0) begin
            $display("positional_pid_term_clamped verification clean");
        end else begin
            $display("positional_pid_term_clamped verification failed");
        end
        $finish;
    end

endmodule

// ===== positional_pid_term_clamped.f =====
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_term.sv
hw/rtl/positional_pid_term_clamped.sv
test/tb_positional_pid_term_clamped.sv
